### hw/rtl/dcmrp_pkg.sv
// dcmrp_pkg: shared constants for the ramp/PID motor drive.
// Holds register indexes, drive mode codes, shared multiplier widths and the ramp step reset.
// No dependencies.
package dcmrp_pkg;

	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 21;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENC_ENABLE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BRAKE_EN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_POWER   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D      = 3'd7;

	localparam logic [1:0] MODE_DIRECT = 2'd0;
	localparam logic [1:0] MODE_SCALED = 2'd1;
	localparam logic [1:0] MODE_RAMPED = 2'd2;
	localparam logic [1:0] MODE_SPEED  = 2'd3;

	localparam logic [7:0] RAMP_STEP_RST = 8'd5;

endpackage

### hw/rtl/dcmrp_if.sv
// dcmrp_if: valid/ready channels for the motor drive tick and its result.
// Standalone; no package dependency.
interface dcmrp_cmd_if;
	logic               valid;
	logic               ready;
	logic [7:0]         power_request;
	logic signed [15:0] target_speed;
	logic signed [31:0] encoder_count;
	logic               direction_request;

	modport source (output valid, power_request, target_speed, encoder_count,
		direction_request, input ready);
	modport sink (input valid, power_request, target_speed, encoder_count,
		direction_request, output ready);
endinterface

interface dcmrp_res_if;
	logic               valid;
	logic               ready;
	logic [7:0]         duty;
	logic               pwm_on;
	logic               speed_level;
	logic               high_side;
	logic               low_side;
	logic               direction;
	logic signed [15:0] measured_speed;

	modport source (output valid, duty, pwm_on, speed_level, high_side, low_side,
		direction, measured_speed, input ready);
	modport sink (input valid, duty, pwm_on, speed_level, high_side, low_side,
		direction, measured_speed, output ready);
endinterface

### hw/rtl/dcmrp_mul.sv
// dcmrp_mul: shared signed multiplier with registered product.
// Depends on dcmrp_pkg for operand widths.
module dcmrp_mul (
	input  logic                                  clk,
	input  logic signed [dcmrp_pkg::MUL_A_W-1:0] a,
	input  logic signed [dcmrp_pkg::MUL_B_W-1:0] b,
	output logic signed [dcmrp_pkg::MUL_P_W-1:0] p
);

	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

### hw/rtl/dc_motor_ramp_pid_drive.sv
// dc_motor_ramp_pid_drive: one H-bridge channel, speed measurement, ramp and PID.
// Accept to result: speed measurement when the encoder is enabled or in speed mode (the
// reciprocal is skipped when the speed saturates), then scaling and level, or the PID passes.
// One tick at a time: the next tick can be taken in the cycle after the result is
// registered, and that waits while an earlier result is not taken.
// Reset (arst_n low) sets ramp_step to 5, other config and level/speed/integrator state to 0.
module dc_motor_ramp_pid_drive #(
	parameter int TICKS_PER_REV = 64,
	parameter int TICK_RATE_HZ  = 100
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	dcmrp_cmd_if.sink                              cmd,
	dcmrp_res_if.source                            res,
	input  logic                                   cfg_wr_en,
	input  logic [dcmrp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dcmrp_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int              SPD_K   = TICK_RATE_HZ * 60;
	localparam logic [53:0]     SAT_THR = 54'(TICKS_PER_REV) << 15;
	// reciprocal of TICKS_PER_REV, exact for quotients below 2^15
	localparam int              RCP_L   = $clog2(TICKS_PER_REV);
	localparam int              RCP_S   = 15 + 2 * RCP_L;
	localparam logic [32:0]     RCP_M   = 33'(((64'd1 << RCP_S) + 64'(TICKS_PER_REV)
		- 64'd1) / 64'(TICKS_PER_REV));

	typedef enum logic [3:0] {
		S_IDLE, S_MSPD, S_DCHK, S_RCP1, S_RCP2, S_RCP3, S_SPD, S_SCL, S_LVL,
		S_P1, S_P2, S_P3, S_P4, S_P5, S_FIN
	} state_t;

	state_t state_q;

	logic [1:0]         mode_q;
	logic               enc_en_q, brake_en_q;
	logic [7:0]         min_q, step_q;
	logic signed [15:0] gp_q, gi_q, gd_q;

	logic [7:0]         pwr_q;
	logic signed [15:0] tgt_q;
	logic [31:0]        cnt_in_q;
	logic               dreq_q;
	logic signed [15:0] prev_q;

	logic [7:0]         level_q;
	logic               bdir_q, cdir_q;
	logic [31:0]        last_count_q;
	logic signed [15:0] last_speed_q;
	logic signed [31:0] integ_q, pterm_q;
	logic signed [34:0] total_q;

	logic               neg_q, sat_q;
	logic [30:0]        x_q;
	logic [63:0]        acc_q;
	logic [14:0]        quo_q;

	logic               ov_q;
	logic [7:0]         duty_q;
	logic               pwm_q, spd_q, hi_q, lo_q, dir_q;
	logic signed [15:0] ms_q;

	logic signed [dcmrp_pkg::MUL_A_W-1:0] mul_a;
	logic signed [dcmrp_pkg::MUL_B_W-1:0] mul_b;
	logic signed [dcmrp_pkg::MUL_P_W-1:0] mul_p;

	dcmrp_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

	logic [31:0] delta;
	assign delta = cnt_in_q - last_count_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_MSPD: begin
				mul_a = 33'(signed'(delta));
				mul_b = 21'(SPD_K);
			end
			S_RCP1: begin
				mul_a = signed'(RCP_M);
				mul_b = {1'b0, x_q[19:0]};
			end
			S_RCP2: begin
				mul_a = signed'(RCP_M);
				mul_b = {10'b0, x_q[30:20]};
			end
			S_SCL: begin
				mul_a = 33'({1'b0, pwr_q});
				mul_b = 21'({1'b0, 8'd255 - min_q});
			end
			S_P1: begin
				mul_a = 33'(tgt_q);
				mul_b = 21'(gp_q);
			end
			S_P2: begin
				mul_a = 33'(17'(tgt_q) - 17'(last_speed_q));
				mul_b = 21'(gi_q);
			end
			S_P3: begin
				mul_a = 33'(17'(prev_q) - 17'(last_speed_q));
				mul_b = 21'(gd_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// speed magnitude and saturation check
	logic [53:0] pabs;
	assign pabs = mul_p[53] ? 54'(-mul_p) : 54'(mul_p);

	// reciprocal product: low part in acc_q, high part on the multiplier output
	logic [63:0] rsum;
	assign rsum = acc_q + (64'(mul_p[52:0]) << 20);

	// scaled power: x/255 exact for x <= 65025
	logic [15:0] sx;
	logic [16:0] sq;
	logic [7:0]  scaled;
	assign sx     = mul_p[15:0];
	assign sq     = (17'(sx) + 17'(sx >> 8) + 17'd1) >> 8;
	assign scaled = (pwr_q == 8'd0) ? 8'd0 : sq[7:0] + min_q;

	// modes 0..2 next level and bridge direction
	logic signed [9:0] up_v, dn_v, scl_s, min_s;
	logic [7:0]        nlvl;
	logic              nbdir;
	assign up_v  = 10'(level_q) + 10'(step_q);
	assign dn_v  = 10'(level_q) - 10'(step_q);
	assign scl_s = signed'({2'b00, scaled});
	assign min_s = signed'({2'b00, min_q});

	always_comb begin
		nlvl  = level_q;
		nbdir = bdir_q;
		case (mode_q)
			dcmrp_pkg::MODE_DIRECT: begin
				nlvl  = pwr_q;
				nbdir = dreq_q;
			end
			dcmrp_pkg::MODE_SCALED: begin
				nlvl  = scaled;
				nbdir = dreq_q;
			end
			default: begin
				if (pwr_q != 8'd0) begin
					if (bdir_q == dreq_q) begin
						if (level_q < scaled) begin
							if (up_v > scl_s) nlvl = scaled;
							else if (up_v < min_s) nlvl = min_q;
							else nlvl = up_v[7:0];
						end else if (level_q > scaled) begin
							if (dn_v < scl_s) nlvl = scaled;
							else nlvl = dn_v[7:0];
						end
					end else begin
						if (dn_v < min_s) nlvl = min_q;
						else nlvl = dn_v[7:0];
						if (nlvl == min_q) nbdir = dreq_q;
					end
				end else if (level_q != 8'd0) begin
					if (dn_v < 10'sd0) nlvl = 8'd0;
					else nlvl = dn_v[7:0];
				end
			end
		endcase
	end

	// PID pieces
	logic signed [33:0] isum;
	logic signed [31:0] isat;
	logic [34:0]        tabs;
	logic [26:0]        tmag;
	logic [7:0]         pid_lvl;
	assign isum = 34'(integ_q) + 34'(signed'(mul_p[32:0]));
	assign isat = (isum > 34'sh7FFFFFFF) ? 32'sh7FFFFFFF :
		(isum < -34'sh80000000) ? -32'sh80000000 : isum[31:0];
	assign tabs = total_q[34] ? 35'(-total_q) : 35'(total_q);
	assign tmag = tabs[34:8];
	always_comb begin
		pid_lvl = (tmag > 27'd255) ? 8'd255 : tmag[7:0];
		if (pid_lvl < min_q) pid_lvl = min_q;
	end

	logic brk;
	assign brk = (level_q == 8'd0) && brake_en_q && (mode_q != dcmrp_pkg::MODE_SPEED)
		&& (pwr_q == 8'd0);

	assign cmd.ready = (state_q == S_IDLE);

	assign res.valid          = ov_q;
	assign res.duty           = duty_q;
	assign res.pwm_on         = pwm_q;
	assign res.speed_level    = spd_q;
	assign res.high_side      = hi_q;
	assign res.low_side       = lo_q;
	assign res.direction      = dir_q;
	assign res.measured_speed = ms_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mode_q       <= dcmrp_pkg::MODE_DIRECT;
			enc_en_q     <= 1'b0;
			brake_en_q   <= 1'b0;
			min_q        <= 8'd0;
			step_q       <= dcmrp_pkg::RAMP_STEP_RST;
			gp_q         <= '0;
			gi_q         <= '0;
			gd_q         <= '0;
			level_q      <= 8'd0;
			bdir_q       <= 1'b0;
			cdir_q       <= 1'b0;
			last_count_q <= '0;
			last_speed_q <= '0;
			integ_q      <= '0;
			ov_q         <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					dcmrp_pkg::REG_DRIVE_MODE: mode_q     <= cfg_data[1:0];
					dcmrp_pkg::REG_ENC_ENABLE: enc_en_q   <= cfg_data[0];
					dcmrp_pkg::REG_BRAKE_EN:   brake_en_q <= cfg_data[0];
					dcmrp_pkg::REG_MIN_POWER:  min_q      <= cfg_data[7:0];
					dcmrp_pkg::REG_RAMP_STEP:  step_q     <= cfg_data[7:0];
					dcmrp_pkg::REG_GAIN_P:     gp_q       <= cfg_data;
					dcmrp_pkg::REG_GAIN_I:     gi_q       <= cfg_data;
					dcmrp_pkg::REG_GAIN_D:     gd_q       <= cfg_data;
					default: ;
				endcase
			end
			if (ov_q && res.ready && state_q != S_FIN) ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						pwr_q    <= cmd.power_request;
						tgt_q    <= cmd.target_speed;
						cnt_in_q <= cmd.encoder_count;
						dreq_q   <= cmd.direction_request;
						prev_q   <= last_speed_q;
						if (enc_en_q || mode_q == dcmrp_pkg::MODE_SPEED) state_q <= S_MSPD;
						else state_q <= S_SCL;
					end
				end
				S_MSPD: state_q <= S_DCHK;
				S_DCHK: begin
					neg_q <= mul_p[53];
					sat_q <= (pabs >= SAT_THR);
					x_q   <= pabs[30:0];
					state_q <= (pabs >= SAT_THR) ? S_SPD : S_RCP1;
				end
				S_RCP1: state_q <= S_RCP2;
				S_RCP2: begin
					acc_q   <= 64'(mul_p[52:0]);
					state_q <= S_RCP3;
				end
				S_RCP3: begin
					quo_q   <= 15'(rsum >> RCP_S);
					state_q <= S_SPD;
				end
				S_SPD: begin
					if (sat_q) last_speed_q <= neg_q ? -16'sd32768 : 16'sd32767;
					else last_speed_q <= neg_q ? -signed'({1'b0, quo_q})
						: signed'({1'b0, quo_q});
					last_count_q <= cnt_in_q;
					state_q <= (mode_q == dcmrp_pkg::MODE_SPEED) ? S_P1 : S_SCL;
				end
				S_SCL: state_q <= S_LVL;
				S_LVL: begin
					level_q <= nlvl;
					bdir_q  <= nbdir;
					cdir_q  <= dreq_q;
					integ_q <= '0;
					state_q <= S_FIN;
				end
				S_P1: state_q <= S_P2;
				S_P2: begin
					pterm_q <= mul_p[31:0];
					state_q <= S_P3;
				end
				S_P3: begin
					integ_q <= isat;
					state_q <= S_P4;
				end
				S_P4: begin
					total_q <= 35'(pterm_q) + 35'(integ_q) + 35'(signed'(mul_p[32:0]));
					state_q <= S_P5;
				end
				S_P5: begin
					level_q <= pid_lvl;
					if (total_q < 0) begin
						cdir_q <= 1'b1;
						bdir_q <= 1'b1;
					end else if (total_q > 0) begin
						cdir_q <= 1'b0;
						bdir_q <= 1'b0;
					end else begin
						bdir_q <= cdir_q;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!ov_q || res.ready) begin
						ov_q   <= 1'b1;
						duty_q <= level_q;
						dir_q  <= cdir_q;
						ms_q   <= last_speed_q;
						hi_q   <= brk | bdir_q;
						lo_q   <= brk | ~bdir_q;
						pwm_q  <= (level_q != 8'd0) && (level_q != 8'd255);
						spd_q  <= brk || (level_q == 8'd255);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("tick accepted while busy");
	a_pwm_mid_duty: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.pwm_on |-> res.duty != 8'd0 && res.duty != 8'd255)
		else $error("pwm at rail duty");
	a_brake_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.high_side && res.low_side |-> res.duty == 8'd0)
		else $error("brake with nonzero duty");
	a_pid_floor: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && mode_q == dcmrp_pkg::MODE_SPEED |-> res.duty >= min_q)
		else $error("speed mode duty under floor");

endmodule

### sim/tb_top.sv
// tb_top: self-checking testbench for dc_motor_ramp_pid_drive.
// Drives random and directed ticks through dcmrp_cmd_if, checks each result beat
// against a built-in drive predictor. Depends on dcmrp_pkg, dcmrp_if and the RTL.
module tb_top;

	typedef struct packed {
		logic [7:0]         power_request;
		logic signed [15:0] target_speed;
		logic signed [31:0] encoder_count;
		logic               direction_request;
	} tick_t;

	typedef struct packed {
		logic [7:0]         duty;
		logic               pwm_on;
		logic               speed_level;
		logic               high_side;
		logic               low_side;
		logic               direction;
		logic signed [15:0] measured_speed;
	} drive_out_t;

	logic clk, arst_n;
	logic cfg_wr_en;
	logic [dcmrp_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [dcmrp_pkg::CFG_DATA_W-1:0] cfg_data;

	dcmrp_cmd_if cmd_ch();
	dcmrp_res_if res_ch();

	dc_motor_ramp_pid_drive DUT (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_ch.sink), .res(res_ch.source),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor copy of registers and state
	logic [1:0] m_mode;
	logic       m_enc, m_brake;
	logic [7:0] m_min, m_step;
	longint     m_kp, m_ki, m_kd;
	logic [7:0] s_level;
	logic       s_bridge, s_cmd_dir;
	logic [31:0] s_last_count;
	longint     s_last_speed, s_isum;

	tick_t      tick_q[$];
	drive_out_t drive_exp_q[$];
	int         mismatches;
	int         accepted_ticks;
	int         idle_cycles;
	bit         stim_done;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic longint clip(longint v, longint lo, longint hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic longint scale_req(longint p);
		if (p == 0) return 0;
		return p * (255 - m_min) / 255 + m_min;
	endfunction

	function automatic drive_out_t predict_drive(tick_t t);
		drive_out_t o;
		longint prev_speed, cur, delta, sc, pt, dt, isum, total, mag;
		logic [31:0] diff;
		prev_speed = s_last_speed;
		cur = s_level;
		if (m_enc || m_mode == dcmrp_pkg::MODE_SPEED) begin
			diff = t.encoder_count - s_last_count;
			delta = longint'($signed(diff));
			s_last_speed = clip(delta * 6000 / 64, -32768, 32767);
			s_last_count = t.encoder_count;
		end
		if (m_mode != dcmrp_pkg::MODE_SPEED) begin
			s_isum = 0;
			s_cmd_dir = t.direction_request;
		end
		case (m_mode)
			dcmrp_pkg::MODE_DIRECT: begin
				cur = t.power_request;
				s_bridge = t.direction_request;
			end
			dcmrp_pkg::MODE_SCALED: begin
				cur = scale_req(t.power_request);
				s_bridge = t.direction_request;
			end
			dcmrp_pkg::MODE_RAMPED: begin
				sc = scale_req(t.power_request);
				if (t.power_request != 0) begin
					if (s_bridge == t.direction_request) begin
						if (cur < sc) cur = clip(cur + m_step, m_min, sc);
						else if (cur > sc) cur = clip(cur - m_step, sc, 255);
					end else begin
						cur = clip(cur - m_step, m_min, 255);
						if (cur == m_min) s_bridge = t.direction_request;
					end
				end else if (cur != 0) begin
					cur = clip(cur - m_step, 0, 255);
				end
			end
			default: begin
				pt = m_kp * longint'(t.target_speed);
				dt = m_kd * (prev_speed - s_last_speed);
				isum = s_isum + m_ki * (longint'(t.target_speed) - s_last_speed);
				s_isum = clip(isum, -64'sd2147483648, 64'sd2147483647);
				total = pt + s_isum + dt;
				mag = (total < 0 ? -total : total) >>> 8;
				if (mag > 255) mag = 255;
				cur = clip(mag, m_min, 255);
				if (total < 0) s_cmd_dir = 1;
				else if (total > 0) s_cmd_dir = 0;
				s_bridge = s_cmd_dir;
			end
		endcase
		s_level = cur[7:0];
		o.duty = s_level;
		o.high_side = s_bridge;
		o.low_side = ~s_bridge;
		o.pwm_on = 0;
		o.speed_level = 0;
		if (s_level == 0) begin
			if (m_brake && m_mode != dcmrp_pkg::MODE_SPEED && t.power_request == 0) begin
				o.speed_level = 1;
				o.high_side = 1;
				o.low_side = 1;
			end
		end else if (s_level == 255) begin
			o.speed_level = 1;
		end else begin
			o.pwm_on = 1;
		end
		o.direction = s_cmd_dir;
		o.measured_speed = s_last_speed[15:0];
		return o;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// driver
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid <= 0;
			send_gap <= 0;
		end else if (!cmd_ch.valid || cmd_ch.ready) begin
			if (cmd_ch.valid) begin
				drive_exp_q.push_back(predict_drive(tick_q.pop_front()));
				accepted_ticks <= accepted_ticks + 1;
			end
			if (send_gap > 0) begin
				cmd_ch.valid <= 0;
				send_gap <= send_gap - 1;
			end else if (tick_q.size() > 0) begin
				cmd_ch.valid <= 1;
				{cmd_ch.power_request, cmd_ch.target_speed, cmd_ch.encoder_count,
					cmd_ch.direction_request} <= tick_q[0];
				send_gap <= gap_len();
			end else begin
				cmd_ch.valid <= 0;
			end
		end
	end

	// monitor
	int stall;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 0;
			stall <= 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				drive_out_t got, want;
				got = {res_ch.duty, res_ch.pwm_on, res_ch.speed_level, res_ch.high_side,
					res_ch.low_side, res_ch.direction, res_ch.measured_speed};
				if (drive_exp_q.size() == 0) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10) $display("unexpected result beat %p", got);
				end else begin
					want = drive_exp_q.pop_front();
					if (got !== want) begin
						mismatches = mismatches + 1;
						if (mismatches <= 10)
							$display("mismatch: expected %p actual %p", want, got);
					end
				end
			end
			if (stall > 0) begin
				res_ch.ready <= 0;
				stall <= stall - 1;
			end else begin
				res_ch.ready <= 1;
				stall <= gap_len();
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_wr_en)
			idle_cycles <= 0;
		else if (!stim_done)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 3000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic write_reg(logic [dcmrp_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_wr_en <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			dcmrp_pkg::REG_DRIVE_MODE: m_mode = val[1:0];
			dcmrp_pkg::REG_ENC_ENABLE: m_enc = val[0];
			dcmrp_pkg::REG_BRAKE_EN:   m_brake = val[0];
			dcmrp_pkg::REG_MIN_POWER:  m_min = val[7:0];
			dcmrp_pkg::REG_RAMP_STEP:  m_step = val[7:0];
			dcmrp_pkg::REG_GAIN_P:     m_kp = longint'($signed(val));
			dcmrp_pkg::REG_GAIN_I:     m_ki = longint'($signed(val));
			default:                   m_kd = longint'($signed(val));
		endcase
		@(posedge clk);
		cfg_wr_en <= 0;
	endtask

	task automatic wait_drained();
		while (tick_q.size() != 0 || cmd_ch.valid || drive_exp_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_count(logic [31:0] prev);
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return prev + 32'($urandom_range(0, 2000)) - 32'd1000;
			2: return prev + 32'd400;
			3: return prev - 32'h7FFF_FFF0;
			default: return prev + 32'($urandom_range(0, 40)) - 32'd20;
		endcase
	endfunction

	task automatic load_ticks(int n, bit pid_friendly);
		tick_t t;
		logic [31:0] cnt;
		t = '0;
		cnt = $urandom();
		for (int i = 0; i < n; i++) begin
			t.power_request = ($urandom_range(0, 5) == 0) ? 8'd0 :
				($urandom_range(0, 7) == 0) ? 8'd255 : 8'($urandom());
			t.target_speed = pid_friendly && $urandom_range(0, 3) != 0 ?
				16'($signed($urandom_range(0, 4000)) - 2000) : 16'($urandom());
			cnt = rand_count(cnt);
			t.encoder_count = cnt;
			t.direction_request = ($urandom_range(0, 5) == 0) ? ~t.direction_request :
				t.direction_request;
			if ($urandom_range(0, 9) == 0) t.direction_request = 1'($urandom());
			tick_q.push_back(t);
		end
	endtask

	task automatic randomize_regs(logic [1:0] mode);
		write_reg(dcmrp_pkg::REG_DRIVE_MODE, 16'(mode));
		write_reg(dcmrp_pkg::REG_ENC_ENABLE, 16'($urandom_range(0, 1)));
		write_reg(dcmrp_pkg::REG_BRAKE_EN, 16'($urandom_range(0, 1)));
		write_reg(dcmrp_pkg::REG_MIN_POWER,
			$urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom_range(0, 120)));
		write_reg(dcmrp_pkg::REG_RAMP_STEP,
			$urandom_range(0, 5) == 0 ? 16'd255 : 16'($urandom_range(1, 40)));
		write_reg(dcmrp_pkg::REG_GAIN_P, 16'($signed($urandom_range(0, 1024)) - 512));
		write_reg(dcmrp_pkg::REG_GAIN_I, 16'($signed($urandom_range(0, 256)) - 128));
		write_reg(dcmrp_pkg::REG_GAIN_D, 16'($signed($urandom_range(0, 256)) - 128));
	endtask

	initial begin
		tick_t t;
		arst_n = 0;
		cfg_wr_en = 0;
		cfg_index = '0;
		cfg_data = '0;
		cmd_ch.power_request = 0;
		cmd_ch.target_speed = 0;
		cmd_ch.encoder_count = 0;
		cmd_ch.direction_request = 0;
		cmd_ch.valid = 0;
		res_ch.ready = 0;
		mismatches = 0;
		accepted_ticks = 0;
		idle_cycles = 0;
		stim_done = 0;
		m_mode = dcmrp_pkg::MODE_DIRECT; m_enc = 0; m_brake = 0; m_min = 0;
		m_step = dcmrp_pkg::RAMP_STEP_RST; m_kp = 0; m_ki = 0; m_kd = 0;
		s_level = 0; s_bridge = 0; s_cmd_dir = 0; s_last_count = 0;
		s_last_speed = 0; s_isum = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;

		// directed: reset defaults, power extremes, both directions
		t = '{8'd0, 16'sd0, 32'sd0, 1'b0};        tick_q.push_back(t);
		t = '{8'd255, 16'sd32767, 32'sd100, 1'b1}; tick_q.push_back(t);
		t = '{8'd1, -16'sd32768, 32'sd0, 1'b0};    tick_q.push_back(t);
		wait_drained();
		// brake, encoder saturation and wrap, ramped reversal
		write_reg(dcmrp_pkg::REG_BRAKE_EN, 16'd1);
		write_reg(dcmrp_pkg::REG_ENC_ENABLE, 16'd1);
		write_reg(dcmrp_pkg::REG_MIN_POWER, 16'd255);
		write_reg(dcmrp_pkg::REG_DRIVE_MODE, 16'(dcmrp_pkg::MODE_SCALED));
		t = '{8'd0, 16'sd0, 32'sh7FFF_FFFF, 1'b0};   tick_q.push_back(t);
		t = '{8'd7, 16'sd0, -32'sh8000_0000, 1'b1};  tick_q.push_back(t);
		wait_drained();
		write_reg(dcmrp_pkg::REG_MIN_POWER, 16'd20);
		write_reg(dcmrp_pkg::REG_RAMP_STEP, 16'd0);
		write_reg(dcmrp_pkg::REG_DRIVE_MODE, 16'(dcmrp_pkg::MODE_RAMPED));
		t = '{8'd200, 16'sd0, 32'sd5, 1'b1}; tick_q.push_back(t);
		wait_drained();
		write_reg(dcmrp_pkg::REG_RAMP_STEP, 16'd60);
		for (int i = 0; i < 6; i++) begin
			t = '{8'd200, 16'sd0, 32'sd5, 1'b1}; tick_q.push_back(t);
		end
		for (int i = 0; i < 5; i++) begin
			t = '{8'd200, 16'sd0, 32'sd5, 1'b0}; tick_q.push_back(t);
		end
		t = '{8'd0, 16'sd0, 32'sd5, 1'b0}; tick_q.push_back(t);
		wait_drained();
		// PID extremes: integral saturation
		write_reg(dcmrp_pkg::REG_DRIVE_MODE, 16'(dcmrp_pkg::MODE_SPEED));
		write_reg(dcmrp_pkg::REG_GAIN_P, 16'h8000);
		write_reg(dcmrp_pkg::REG_GAIN_I, 16'h7FFF);
		write_reg(dcmrp_pkg::REG_GAIN_D, 16'h7FFF);
		write_reg(dcmrp_pkg::REG_MIN_POWER, 16'd0);
		for (int i = 0; i < 4; i++) begin
			t = '{8'd9, 16'sd32767, 32'(-i * 30000000), 1'b0}; tick_q.push_back(t);
		end
		t = '{8'd0, 16'sd0, 32'(-90000000), 1'b1}; tick_q.push_back(t);
		wait_drained();

		// random phases
		for (int ph = 0; ph < 16; ph++) begin
			randomize_regs(ph < 4 ? 2'(ph) : 2'($urandom_range(0, 3)));
			load_ticks(75, m_mode == dcmrp_pkg::MODE_SPEED);
			wait_drained();
		end
		stim_done = 1;
		if (mismatches == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end
endmodule
